### hdl/sdli_pkg.sv
`timescale 1ns / 1ps

package sdli_pkg;

    // list size and fixed field widths
    localparam int CAPACITY_DEF = 16;
    localparam int DATA_W       = 32;
    localparam int STATUS_W     = 2;
    localparam int FIELD_W      = 5;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_INSERTED  = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_DUPLICATE = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_READOUT   = 2'd3;

    // input action codes
    localparam logic ACT_INSERT  = 1'b0;
    localparam logic ACT_READOUT = 1'b1;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_INS,
        ST_READ
    } state_t;

    // per-cycle commands broadcast along the chain
    typedef struct packed {
        logic cmp_en;
        logic ins_en;
        logic rot_en;
    } cell_ctrl_t;

endpackage

### hdl/sdli_cell.sv
`timescale 1ns / 1ps

module sdli_cell (
    input  logic                                 clk,
    input  sdli_pkg::cell_ctrl_t                 ctrl,
    input  logic                                 occ,
    input  logic                                 last,
    input  logic signed [sdli_pkg::DATA_W-1:0]   key,
    input  logic signed [sdli_pkg::DATA_W-1:0]   prev_entry,
    input  logic                                 prev_gt,
    input  logic signed [sdli_pkg::DATA_W-1:0]   next_entry,
    input  logic signed [sdli_pkg::DATA_W-1:0]   head,
    output logic signed [sdli_pkg::DATA_W-1:0]   entry,
    output logic                                 gt,
    output logic                                 eq
);
    import sdli_pkg::*;

    logic signed [DATA_W-1:0] entry_reg;
    logic signed [DATA_W-1:0] entry_next;
    logic                     gt_reg;
    logic                     eq_reg;

    // compare stored word against the key being inserted
    always_ff @(posedge clk)
    begin
        if (ctrl.cmp_en)
        begin
            gt_reg <= occ && (entry_reg > key);
            eq_reg <= occ && (entry_reg == key);
        end
    end

    // insert shifts smaller words down, readout rotates towards the head
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins_en && !gt_reg)
        begin
            entry_next = prev_gt ? key : prev_entry;
        end
        else if (ctrl.rot_en)
        begin
            entry_next = last ? head : next_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign gt    = gt_reg;
    assign eq    = eq_reg;

endmodule

### hdl/sorted_descending_list_insert.sv
`timescale 1ns / 1ps
// insert: result word registered from the shift pass (ST_INS), which follows the compare pass (ST_CMP)
// readout: one result word per entry, one per cycle while the output is not stalled
// inserts: the next request is accepted no earlier than the shift pass of the one before
// readout: at least one word, each registered from ST_READ, the chain rotating one place per word
// reset: asynchronous active low, list empty, no result pending, stored words left undefined
module sorted_descending_list_insert #(
    parameter int CAPACITY = sdli_pkg::CAPACITY_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  action,
    input  logic signed [sdli_pkg::DATA_W-1:0]    value,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [sdli_pkg::STATUS_W-1:0]         status,
    output logic [sdli_pkg::FIELD_W-1:0]          position,
    output logic [sdli_pkg::FIELD_W-1:0]          count,
    output logic signed [sdli_pkg::DATA_W-1:0]    entry,
    output logic                                  empty_res,
    output logic                                  final_res
);
    import sdli_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    state_t      state_reg;
    state_t      state_next;
    cell_ctrl_t  ctrl;

    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;
    logic [CW-1:0]            rd_idx_reg;
    logic [CW-1:0]            rd_idx_next;
    logic signed [DATA_W-1:0] value_reg;

    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [STATUS_W-1:0]      status_reg;
    logic [STATUS_W-1:0]      status_next;
    logic [CW-1:0]            position_reg;
    logic [CW-1:0]            position_next;
    logic [CW-1:0]            count_out_reg;
    logic [CW-1:0]            count_out_next;
    logic signed [DATA_W-1:0] entry_reg;
    logic signed [DATA_W-1:0] entry_next;
    logic                     empty_reg;
    logic                     empty_next;
    logic                     final_reg;
    logic                     final_next;

    logic signed [DATA_W-1:0] cell_entry [CAPACITY];
    logic [CAPACITY:0]        gt_vec;
    logic [CAPACITY-1:0]      eq_vec;
    logic [CAPACITY-1:0]      occ_vec;
    logic [CAPACITY-1:0]      last_vec;

    logic                     accept;
    logic                     load_ok;
    logic                     is_full;
    logic                     is_dup;
    logic                     rd_done;
    logic [CW-1:0]            slot;
    logic [CW-1:0]            count_inc;
    logic [CW+FIELD_W-1:0]    position_ext;
    logic [CW+FIELD_W-1:0]    count_ext;

    // occupancy and rotation end of each cell, from the fill count
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            occ_vec[i]  = (CW'(i) < count_reg);
            last_vec[i] = (CW'(i) == count_reg - CW'(1));
        end
    end

    // chain of compare-and-shift cells
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic signed [DATA_W-1:0] prev_e;
            logic signed [DATA_W-1:0] next_e;
            logic                     prev_g;
            if (g == 0)
            begin : g_first
                assign prev_e = value_reg;
                assign prev_g = 1'b0;
            end
            else
            begin : g_mid
                assign prev_e = cell_entry[g-1];
                assign prev_g = gt_vec[g-1];
            end
            if (g == CAPACITY - 1)
            begin : g_end
                assign next_e = cell_entry[0];
            end
            else
            begin : g_inner
                assign next_e = cell_entry[g+1];
            end
            sdli_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .occ        (occ_vec[g]),
                .last       (last_vec[g]),
                .key        (value_reg),
                .prev_entry (prev_e),
                .prev_gt    (prev_g),
                .next_entry (next_e),
                .head       (cell_entry[0]),
                .entry      (cell_entry[g]),
                .gt         (gt_vec[g]),
                .eq         (eq_vec[g])
            );
        end
    endgenerate
    assign gt_vec[CAPACITY] = 1'b0;

    // insert slot: larger-than flags form a thermometer, find its edge
    always_comb
    begin
        slot = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (gt_vec[i] && !gt_vec[i+1])
            begin
                slot = slot | CW'(i + 1);
            end
        end
    end

    assign is_dup    = |eq_vec;
    assign is_full   = (count_reg == CW'(CAPACITY));
    assign count_inc = count_reg + CW'(1);
    assign load_ok   = !out_valid_reg || out_ready;
    assign rd_done   = (count_reg == '0) || (rd_idx_reg == count_reg - CW'(1));
    assign accept    = in_valid && in_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (action == ACT_READOUT) ? ST_READ : ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_INS;
            end
            ST_INS, ST_READ:
            begin
                if (load_ok && (state_reg == ST_INS || rd_done))
                begin
                    if (in_valid)
                    begin
                        state_next = (action == ACT_READOUT) ? ST_READ : ST_CMP;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready    = 1'b0;
        ctrl        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_CMP:
            begin
                ctrl.cmp_en = 1'b1;
            end
            ST_INS:
            begin
                in_ready    = load_ok;
                ctrl.ins_en = load_ok && !is_full && !is_dup;
            end
            ST_READ:
            begin
                in_ready    = load_ok && rd_done;
                ctrl.rot_en = load_ok && (count_reg != '0);
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // fill count and readout index
    always_comb
    begin
        count_next  = ctrl.ins_en ? count_inc : count_reg;
        rd_idx_next = rd_idx_reg;
        if (accept)
        begin
            rd_idx_next = '0;
        end
        else if (ctrl.rot_en)
        begin
            rd_idx_next = rd_idx_reg + CW'(1);
        end
    end

    // result word register
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        position_next  = position_reg;
        count_out_next = count_out_reg;
        entry_next     = entry_reg;
        empty_next     = empty_reg;
        final_next     = final_reg;
        if (load_ok && state_reg == ST_INS)
        begin
            out_valid_next = 1'b1;
            entry_next     = '0;
            empty_next     = 1'b0;
            final_next     = 1'b1;
            position_next  = '0;
            count_out_next = count_reg;
            priority if (is_full)
            begin
                status_next = STAT_FULL;
            end
            else if (is_dup)
            begin
                status_next = STAT_DUPLICATE;
            end
            else
            begin
                status_next    = STAT_INSERTED;
                position_next  = slot;
                count_out_next = count_inc;
            end
        end
        else if (load_ok && state_reg == ST_READ)
        begin
            out_valid_next = 1'b1;
            status_next    = STAT_READOUT;
            position_next  = rd_idx_reg;
            count_out_next = count_reg;
            empty_next     = (count_reg == '0);
            final_next     = rd_done;
            entry_next     = (count_reg == '0) ? '0 : cell_entry[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            value_reg <= value;
        end
        status_reg    <= status_next;
        position_reg  <= position_next;
        count_out_reg <= count_out_next;
        entry_reg     <= entry_next;
        empty_reg     <= empty_next;
        final_reg     <= final_next;
    end

    // position and count leave at the fixed field width
    assign position_ext = {{FIELD_W{1'b0}}, position_reg};
    assign count_ext    = {{FIELD_W{1'b0}}, count_out_reg};

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign position  = position_ext[FIELD_W-1:0];
    assign count     = count_ext[FIELD_W-1:0];
    assign entry     = entry_reg;
    assign empty_res = empty_reg;
    assign final_res = final_reg;

endmodule

### hdl/sdli_checker.sv
`timescale 1ns / 1ps

module sdli_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic [sdli_pkg::STATUS_W-1:0]       status,
    input  logic [sdli_pkg::FIELD_W-1:0]        position,
    input  logic [sdli_pkg::FIELD_W-1:0]        count,
    input  logic signed [sdli_pkg::DATA_W-1:0]  entry,
    input  logic                                empty_res,
    input  logic                                final_res
);
    import sdli_pkg::*;

    // a stalled result word holds its status, position, entry and final flag
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(position)
            && $stable(entry) && $stable(final_res))
        else $error("result word changed while stalled");

    // insert results are single words with no entry
    a_insert_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STAT_READOUT |-> final_res && !empty_res && entry == '0)
        else $error("insert result malformed");

    // empty readout word
    a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && empty_res |-> status == STAT_READOUT && count == '0 && position == '0
            && final_res)
        else $error("empty readout malformed");

    // rejected insert reports position zero
    a_reject_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STAT_DUPLICATE || status == STAT_FULL) |-> position == '0)
        else $error("rejected insert with non-zero position");

endmodule

bind sorted_descending_list_insert sdli_checker u_sdli_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .position  (position),
    .count     (count),
    .entry     (entry),
    .empty_res (empty_res),
    .final_res (final_res)
);
